// ===== sv/ordered_list_append_remove_macros.svh =====
// Assertion macros shared by the list block.
`ifndef ORDERED_LIST_APPEND_REMOVE_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OLAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, checked out of reset.
`define OLAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

// ===== sv/olar_pkg.sv =====
`timescale 1ns / 1ps

package olar_pkg;

    // Default number of entries the list can hold.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths of the input and result words.
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int IN_FLD_W  = CMD_W + VALUE_W + POS_W;
    localparam int OUT_FLD_W = STATUS_W + VALUE_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_DUMP_RD,
        S_OUT
    } state_t;

endpackage

// ===== sv/ordered_list_append_remove.sv =====
`timescale 1ns / 1ps
`include "ordered_list_append_remove_macros.svh"

// Bounded ordered list of up to DEPTH signed 32-bit values held in one
// memory with a single write port and a single registered read port. The
// block works on one word at a time: it is ready only while idle. An append
// or any rejected command is accepted and then offers its result word. A
// remove at position p from a list of length L moves each later entry one
// place forward, each move a read and then a write through the one memory
// port pair, before its result word. A dump emits one result word per
// entry, each a memory read and then the result, and the result side may
// stall any word. Entries start undefined and are only read after being
// written, so no clearing pass runs after reset.
module ordered_list_append_remove #(
    parameter int DEPTH = olar_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: command[1:0], value[33:2], position[38:34].
    input  logic [olar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: status[1:0], element[33:2], count[38:34].
    output logic [olar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import olar_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int PAD_W = OUT_TDATA_W - OUT_FLD_W;

    // Control and result registers.
    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  last_reg, last_next;
    logic                  dump_reg, dump_next;

    // Entry memory and its ports.
    logic signed [VALUE_W-1:0] entry_store_mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      mem_rd_en;
    logic [IDX_W-1:0]          mem_rd_addr;
    logic                      mem_wr_en;
    logic [IDX_W-1:0]          mem_wr_addr;
    logic signed [VALUE_W-1:0] mem_wr_data;

    // Input word fields.
    logic [CMD_W-1:0]          in_cmd;
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_pos;
    logic                      in_fire;
    logic                      out_fire;
    logic                      full;
    logic                      append_ok;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          len_ext;
    logic signed [VALUE_W-1:0] out_element;

    assign in_cmd    = s_axis_tdata[CMD_W-1:0];
    assign in_value  = s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign in_pos    = s_axis_tdata[IN_FLD_W-1:CMD_W+VALUE_W];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign full      = (len_reg == LEN_W'(DEPTH));
    assign append_ok = in_fire && (in_cmd == CMD_APPEND) && !full;
    assign pos_ext   = CMP_W'(in_pos);
    assign len_ext   = CMP_W'(len_reg);

    // Result word; the element is only nonzero on dump results.
    assign out_element  = dump_reg ? rd_data_reg : '0;
    assign m_axis_tdata = {{PAD_W{1'b0}}, COUNT_W'(len_reg), out_element, status_reg};
    assign m_axis_tlast = last_reg;

    // Handshake and memory port controls.
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        m_axis_tvalid = (state_reg == S_OUT);
        mem_rd_en     = 1'b0;
        mem_rd_addr   = idx_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = idx_reg;
        mem_wr_data   = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_cmd == CMD_APPEND) && !full)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(len_reg);
                    mem_wr_data = in_value;
                end
            end
            S_SH_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg + IDX_W'(1);
            end
            S_SH_WR:
            begin
                mem_wr_en = 1'b1;
            end
            S_DUMP_RD:
            begin
                mem_rd_en = 1'b1;
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer next state and result register updates.
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        last_next   = last_reg;
        dump_next   = dump_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next  = 1'b1;
                    dump_next  = 1'b0;
                    state_next = S_OUT;
                    unique case (in_cmd)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                len_next    = len_reg + LEN_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if ((in_pos == '0) || (pos_ext > len_ext))
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next = IDX_W'(in_pos - POS_W'(1));
                                if (pos_ext < len_ext)
                                begin
                                    state_next = S_SH_RD;
                                end
                                else
                                begin
                                    status_next = ST_OK;
                                    len_next    = len_reg - LEN_W'(1);
                                end
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                dump_next  = 1'b1;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if ((LEN_W'(idx_reg) + LEN_W'(2)) < len_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    status_next = ST_OK;
                    len_next    = len_reg - LEN_W'(1);
                    state_next  = S_OUT;
                end
            end
            S_DUMP_RD:
            begin
                status_next = ST_OK;
                last_next   = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (dump_reg && !last_reg)
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_DUMP_RD;
                    end
                    else
                    begin
                        dump_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;
            dump_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            dump_reg   <= dump_next;
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            entry_store_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= entry_store_mem[mem_rd_addr];
        end
    end

    // Checks on the sequencer.
    `OLAR_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_reg <= LEN_W'(DEPTH))
    `OLAR_ASSERT_IMP(a_one_side, clk, rst_n, s_axis_tready, !m_axis_tvalid)
    `OLAR_ASSERT_NEXT(a_append_grows, clk, rst_n, append_ok, len_reg == $past(len_reg) + LEN_W'(1))
    `OLAR_ASSERT_NEXT(a_last_frees, clk, rst_n, out_fire && m_axis_tlast, s_axis_tready)
endmodule

// ===== verif/ordered_list_append_remove_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_append_remove_tb;

    import olar_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 40;
    // Command code the block does not define; it must be rejected.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result word as the block should produce it.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  element;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } reply_t;

    // Shadow copy of the list that predicts every result word.
    class list_shadow;
        logic [VALUE_W-1:0] entries [LIST_DEPTH];
        int unsigned held;
        reply_t replies_due[$];
        int unsigned mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void queue_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] elem,
                                  logic lst);
            reply_t r;
            r.status = st;
            r.element = elem;
            r.count = COUNT_W'(held);
            r.last = lst;
            replies_due.push_back(r);
        endfunction

        // Updates the list for one accepted command word and queues its results.
        function void apply_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                                    logic [POS_W-1:0] pos);
            int unsigned i;
            case (cmd)
                CMD_APPEND:
                begin
                    if (held >= LIST_DEPTH)
                    begin
                        queue_reply(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        entries[held] = val;
                        held++;
                        queue_reply(ST_OK, '0, 1'b1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (pos == 0 || pos > held)
                    begin
                        queue_reply(ST_RANGE, '0, 1'b1);
                    end
                    else
                    begin
                        // Close the gap by moving every later entry one place forward.
                        for (i = pos - 1; i + 1 < held; i++)
                        begin
                            entries[i] = entries[i + 1];
                        end
                        held--;
                        queue_reply(ST_OK, '0, 1'b1);
                    end
                end
                CMD_DUMP:
                begin
                    if (held == 0)
                    begin
                        queue_reply(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (i = 0; i < held; i++)
                        begin
                            queue_reply(ST_OK, entries[i], i + 1 == held);
                        end
                    end
                end
                default:
                begin
                    queue_reply(ST_RANGE, '0, 1'b1);
                end
            endcase
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void check_reply(logic [OUT_TDATA_W-1:0] word, logic lst);
            reply_t want;
            logic [STATUS_W-1:0] got_status;
            logic [VALUE_W-1:0]  got_element;
            logic [COUNT_W-1:0]  got_count;
            got_status = word[STATUS_W-1:0];
            got_element = word[STATUS_W +: VALUE_W];
            got_count = word[STATUS_W + VALUE_W +: COUNT_W];
            if (replies_due.size() == 0)
            begin
                $error("unexpected result word: status %0d, element %0h, count %0d",
                       got_status, got_element, got_count);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                mismatches++;
            end
            if (got_element !== want.element)
            begin
                $error("element: expected %0h, actual %0h", want.element, got_element);
                mismatches++;
            end
            if (got_count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got_count);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    list_shadow sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic long_hold_req = 1'b0;
    int unsigned hold_left = 0;

    ordered_list_append_remove uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Result side: check accepted words, then pick the ready level for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_reply(m_axis_tdata, m_axis_tlast);
        end
        if (long_hold_req)
        begin
            hold_left = LONG_HOLD;
            long_hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Guard against a hung block.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one command word, with random idle cycles ahead of it.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'({pos, val, cmd});
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.apply_command(cmd, val, pos);
    endtask

    // Random value, now and then one of the extremes.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // One random command; append_pct steers the list toward full or empty.
    task automatic random_item(input int unsigned append_pct);
        int unsigned r;
        logic [POS_W-1:0] pos;
        r = $urandom_range(99);
        // Mostly a position that exists, otherwise anything the field holds.
        if (sb.held > 0 && $urandom_range(9) < 8)
        begin
            pos = POS_W'($urandom_range(sb.held, 1));
        end
        else
        begin
            pos = POS_W'($urandom_range(31));
        end
        if (r < append_pct)
        begin
            send_cmd(CMD_APPEND, pick_value(), POS_W'($urandom));
        end
        else if (r < append_pct + 20)
        begin
            send_cmd(CMD_DUMP, $urandom, POS_W'($urandom));
        end
        else if (r < append_pct + 23)
        begin
            send_cmd(CMD_UNUSED, $urandom, pos);
        end
        else
        begin
            send_cmd(CMD_REMOVE, $urandom, pos);
        end
    endtask

    initial
    begin
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list cases and the undefined command.
        send_cmd(CMD_DUMP, '0, '0);
        send_cmd(CMD_REMOVE, '0, 5'd0);
        send_cmd(CMD_REMOVE, '0, 5'd1);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);

        // Fill to capacity with the value extremes first, then overflow once.
        send_cmd(CMD_APPEND, 32'h8000_0000, '0);
        send_cmd(CMD_APPEND, 32'h7FFF_FFFF, '0);
        send_cmd(CMD_APPEND, 32'h0000_0000, '0);
        send_cmd(CMD_APPEND, 32'hFFFF_FFFF, '0);
        for (i = 4; i < LIST_DEPTH; i++)
        begin
            send_cmd(CMD_APPEND, $urandom, '0);
        end
        send_cmd(CMD_APPEND, 32'h1234_5678, '0);
        send_cmd(CMD_DUMP, '0, '0);

        // Removal at position zero, one past the end, the head and the tail.
        send_cmd(CMD_REMOVE, '0, 5'd0);
        send_cmd(CMD_REMOVE, '0, 5'd17);
        send_cmd(CMD_REMOVE, '0, 5'd1);
        send_cmd(CMD_REMOVE, '0, 5'd15);
        send_cmd(CMD_DUMP, '0, '0);

        // Random phases with different idle patterns on each side.
        for (i = 0; i < 90; i++)
        begin
            random_item(50);
        end
        send_idle_pct = 54;
        for (i = 0; i < 90; i++)
        begin
            random_item(30);
        end
        send_idle_pct = 0;
        recv_stall_pct = 54;
        // Long hold-off on the result side while words keep coming.
        long_hold_req <= 1'b1;
        for (i = 0; i < 90; i++)
        begin
            random_item(55);
        end
        send_idle_pct = 33;
        recv_stall_pct = 33;
        for (i = 0; i < 90; i++)
        begin
            random_item(40);
        end
        s_axis_tvalid <= 1'b0;

        // Let every predicted word arrive, then watch for stray ones.
        while (sb.replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
